>>> rtl/lge_pkg.sv
// ---------------------------------------------------------------------------
// lge_pkg
// shared types and constants of the life generation row engine
// ---------------------------------------------------------------------------
package lge_pkg;

  localparam int ROW_W      = 64;
  localparam int ROW_IDX_W  = 12;
  localparam int NROWS_W    = 13;
  localparam int NCOLS_W    = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = 2;
  localparam int OUT_CNT_W  = 3;

  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [ROW_IDX_W-1:0]  row_idx_t;
  typedef logic [NROWS_W-1:0]    nrows_t;
  typedef logic [NCOLS_W-1:0]    ncols_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [3:0]            nbr_t;
  typedef logic [OUT_PTR_W-1:0]  out_ptr_t;
  typedef logic [OUT_CNT_W-1:0]  out_cnt_t;

  localparam cfg_idx_t CFG_NUM_ROWS = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_NUM_COLS = cfg_idx_t'(1);

  localparam nrows_t NUM_ROWS_RESET = nrows_t'(1);
  localparam ncols_t NUM_COLS_RESET = ncols_t'(64);

  // b3/s23
  localparam nbr_t BIRTH_COUNT   = nbr_t'(3);
  localparam nbr_t SURVIVE_COUNT = nbr_t'(2);

  typedef struct packed {
    logic changed;
    logic alive;
  } eval_flags_t;

  typedef struct packed {
    row_t     next_row;
    row_idx_t row_index;
    logic     last;
    logic     stable;
  } result_t;

  typedef struct packed {
    logic room_two;
    logic not_empty;
  } fifo_status_t;

endpackage

>>> rtl/lge_if.sv
// ---------------------------------------------------------------------------
// lge channel interfaces
// row input, result output and configuration write channels
// ---------------------------------------------------------------------------
interface lge_row_if;
  logic            valid;
  logic            ready;
  lge_pkg::row_t   row_cells;

  modport source (output valid, output row_cells, input ready);
  modport sink   (input valid, input row_cells, output ready);
endinterface

interface lge_result_if;
  logic              valid;
  logic              ready;
  lge_pkg::row_t     next_row;
  lge_pkg::row_idx_t row_index;
  logic              last;
  logic              stable;

  modport source (output valid, output next_row, output row_index, output last,
                  output stable, input ready);
  modport sink   (input valid, input next_row, input row_index, input last,
                  input stable, output ready);
endinterface

interface lge_cfg_if;
  logic               valid;
  logic               ready;
  lge_pkg::cfg_idx_t  index;
  lge_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/lge_cell.sv
// ---------------------------------------------------------------------------
// lge_cell
// one cell lane: neighbor count and b3/s23 rule
// ---------------------------------------------------------------------------
module lge_cell (
  input  logic [2:0] up,
  input  logic [2:0] mid,
  input  logic [2:0] down,
  output logic       next
);

  lge_pkg::nbr_t nbrs;

  assign nbrs = lge_pkg::nbr_t'(up[0]) + lge_pkg::nbr_t'(up[1]) + lge_pkg::nbr_t'(up[2])
              + lge_pkg::nbr_t'(mid[0]) + lge_pkg::nbr_t'(mid[2])
              + lge_pkg::nbr_t'(down[0]) + lge_pkg::nbr_t'(down[1])
              + lge_pkg::nbr_t'(down[2]);

  assign next = (nbrs == lge_pkg::BIRTH_COUNT)
             || (mid[1] && (nbrs == lge_pkg::SURVIVE_COUNT));

endmodule

>>> rtl/lge_row_eval.sv
// ---------------------------------------------------------------------------
// lge_row_eval
// row of cell lanes plus merge of per-lane change and live flags
// ---------------------------------------------------------------------------
module lge_row_eval #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0]      up,
  input  logic [COLS-1:0]      mid,
  input  logic [COLS-1:0]      down,
  input  logic [COLS-1:0]      mask,
  output logic [COLS-1:0]      next_row,
  output lge_pkg::eval_flags_t flags
);

  logic [COLS+1:0] up_pad;
  logic [COLS+1:0] mid_pad;
  logic [COLS+1:0] down_pad;
  logic [COLS-1:0] raw;

  // dead cells beyond both edges
  assign up_pad   = {1'b0, up & mask, 1'b0};
  assign mid_pad  = {1'b0, mid & mask, 1'b0};
  assign down_pad = {1'b0, down & mask, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    lge_cell u_cell (
      .up   (up_pad[c+2:c]),
      .mid  (mid_pad[c+2:c]),
      .down (down_pad[c+2:c]),
      .next (raw[c])
    );
  end

  assign next_row      = raw & mask;
  assign flags.changed = |(next_row ^ (mid & mask));
  assign flags.alive   = |next_row;

endmodule

>>> rtl/lge_out_fifo.sv
// ---------------------------------------------------------------------------
// lge_out_fifo
// small result queue, up to two writes and one read per cycle
// ---------------------------------------------------------------------------
module lge_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push0,
  input  lge_pkg::result_t      push0_data,
  input  logic                  push1,
  input  lge_pkg::result_t      push1_data,
  input  logic                  pop,
  output lge_pkg::result_t      head,
  output lge_pkg::fifo_status_t status
);

  lge_pkg::result_t  entries [lge_pkg::OUT_DEPTH];
  lge_pkg::out_ptr_t wr_ptr;
  lge_pkg::out_ptr_t rd_ptr;
  lge_pkg::out_cnt_t count;
  lge_pkg::out_cnt_t count_next;

  assign count_next = count + lge_pkg::out_cnt_t'(push0) + lge_pkg::out_cnt_t'(push1)
                    - lge_pkg::out_cnt_t'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + lge_pkg::out_ptr_t'(push0) + lge_pkg::out_ptr_t'(push1);
      rd_ptr <= rd_ptr + lge_pkg::out_ptr_t'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= push0_data;
    end
    if (push1) begin
      entries[wr_ptr + lge_pkg::out_ptr_t'(1)] <= push1_data;
    end
  end

  assign head             = entries[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.room_two  = (count <= lge_pkg::out_cnt_t'(lge_pkg::OUT_DEPTH - 2));

endmodule

>>> rtl/life_generation_row_engine.sv
// ---------------------------------------------------------------------------
// life_generation_row_engine
// streaming b3/s23 game of life, one board row per transfer
// ---------------------------------------------------------------------------
// usage:
//   cfg     : register writes (index 0 = num_rows, index 1 = num_cols), always
//             ready; write only while no board is in flight
//   rows    : one row per transfer, top to bottom, bit c = column c
//   results : next-generation rows with row_index, last and stable
// a row's result leaves once the row below it has arrived; the final row of
// a board with more than one row gives two results (the row above it and
// itself), the first row of such a board gives none
// a result is written to the result buffer when the row that causes it is taken
// throughput: one row per cycle while rows is ready, all cells of a row
//   evaluated in parallel lanes
// results queue in a 4-entry buffer; rows stays ready while two entries are
// free, so a stalled receiver stops rows once three results wait
// reset: num_rows = 1, num_cols = 64, stored rows, counter and flags clear,
//   result buffer empty
// ---------------------------------------------------------------------------
module life_generation_row_engine #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 4096
) (
  input  logic       clk,
  input  logic       rst,
  lge_cfg_if.sink    cfg,
  lge_row_if.sink    rows,
  lge_result_if.source results
);

  localparam int CNT_W = $clog2(MAX_ROWS);
  localparam int CMP_W = (CNT_W + 1 > lge_pkg::NROWS_W) ? CNT_W + 1 : lge_pkg::NROWS_W;

  lge_pkg::nrows_t num_rows;
  lge_pkg::ncols_t num_cols;

  logic [MAX_COLS-1:0] upper_row;
  logic [MAX_COLS-1:0] middle_row;
  logic [CNT_W-1:0]    row_counter;
  logic                change_seen;
  logic                alive_seen;

  logic [MAX_COLS-1:0] mask;
  logic [MAX_COLS-1:0] cur;
  logic [MAX_COLS-1:0] nxt_mid;
  logic [MAX_COLS-1:0] nxt_fin;
  lge_pkg::eval_flags_t flags_mid;
  lge_pkg::eval_flags_t flags_fin;

  lge_pkg::nrows_t     rows_eff;
  logic [CMP_W-1:0]    cnt_p1;
  logic                is_last;
  logic                has_mid;
  logic                accept;
  logic                change_any;
  logic                alive_any;

  lge_pkg::result_t      res_mid;
  lge_pkg::result_t      res_fin;
  lge_pkg::result_t      head;
  lge_pkg::fifo_status_t fifo_stat;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= lge_pkg::NUM_ROWS_RESET;
      num_cols <= lge_pkg::NUM_COLS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        lge_pkg::CFG_NUM_ROWS: num_rows <= lge_pkg::nrows_t'(cfg.data);
        lge_pkg::CFG_NUM_COLS: num_cols <= lge_pkg::ncols_t'(cfg.data);
        default: ;
      endcase
    end
  end

  // column mask, column 0 always in use
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign mask[c] = (c == 0) || (lge_pkg::ncols_t'(c) < num_cols);
  end

  assign cur = rows.row_cells[MAX_COLS-1:0] & mask;

  assign rows_eff = (num_rows == '0) ? lge_pkg::nrows_t'(1) : num_rows;
  assign cnt_p1   = CMP_W'(row_counter) + CMP_W'(1);
  assign is_last  = (cnt_p1 >= CMP_W'(rows_eff)) || (cnt_p1 >= CMP_W'(MAX_ROWS));
  assign has_mid  = (row_counter != '0);

  assign rows.ready = fifo_stat.room_two;
  assign accept     = rows.valid && rows.ready;

  lge_row_eval #(.COLS(MAX_COLS)) u_eval_mid (
    .up       (upper_row),
    .mid      (middle_row),
    .down     (cur),
    .mask     (mask),
    .next_row (nxt_mid),
    .flags    (flags_mid)
  );

  lge_row_eval #(.COLS(MAX_COLS)) u_eval_fin (
    .up       (middle_row),
    .mid      (cur),
    .down     ({MAX_COLS{1'b0}}),
    .mask     (mask),
    .next_row (nxt_fin),
    .flags    (flags_fin)
  );

  assign change_any = change_seen || (has_mid && flags_mid.changed) || flags_fin.changed;
  assign alive_any  = alive_seen || (has_mid && flags_mid.alive) || flags_fin.alive;

  assign res_mid.next_row  = lge_pkg::row_t'(nxt_mid);
  assign res_mid.row_index = lge_pkg::row_idx_t'(row_counter - CNT_W'(1));
  assign res_mid.last      = 1'b0;
  assign res_mid.stable    = 1'b0;

  assign res_fin.next_row  = lge_pkg::row_t'(nxt_fin);
  assign res_fin.row_index = lge_pkg::row_idx_t'(row_counter);
  assign res_fin.last      = 1'b1;
  assign res_fin.stable    = !change_any || !alive_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row   <= '0;
      middle_row  <= '0;
      row_counter <= '0;
      change_seen <= 1'b0;
      alive_seen  <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        upper_row   <= '0;
        middle_row  <= '0;
        row_counter <= '0;
        change_seen <= 1'b0;
        alive_seen  <= 1'b0;
      end else begin
        upper_row   <= middle_row;
        middle_row  <= cur;
        row_counter <= row_counter + CNT_W'(1);
        change_seen <= change_seen || (has_mid && flags_mid.changed);
        alive_seen  <= alive_seen || (has_mid && flags_mid.alive);
      end
    end
  end

  lge_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push0      (accept && (has_mid || is_last)),
    .push0_data (has_mid ? res_mid : res_fin),
    .push1      (accept && has_mid && is_last),
    .push1_data (res_fin),
    .pop        (results.valid && results.ready),
    .head       (head),
    .status     (fifo_stat)
  );

  assign results.valid     = fifo_stat.not_empty;
  assign results.next_row  = head.next_row;
  assign results.row_index = head.row_index;
  assign results.last      = head.last;
  assign results.stable    = head.stable;

  // end of board returns the counter to the top
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && is_last |=> row_counter == '0)
    else $error("row counter not cleared after final row");

  // inner rows advance the counter by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !is_last |=> row_counter == CNT_W'($past(row_counter) + CNT_W'(1)))
    else $error("row counter did not advance");

  // stable only accompanies the final row
  a_stable_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.last |-> !results.stable)
    else $error("stable set on a non-final result");

  // a row that produces results always finds buffer room
  a_room: assert property (@(posedge clk) disable iff (rst)
    rows.valid && rows.ready |-> fifo_stat.room_two)
    else $error("row taken without buffer room");

endmodule
